### hw/rtl/sdpm_pkg.sv
// ----------------------------------------------------------------------------
// sdpm_pkg
// Types and constants shared by the stereo delay pan mixer modules.
// ----------------------------------------------------------------------------
package sdpm_pkg;

    localparam int CFG_IW = 2;
    localparam int CFG_DW = 16;

    localparam logic [CFG_IW-1:0] CFG_DELAY_LEFT  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_DELAY_RIGHT = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_GAIN_LEFT   = 2'd2;
    localparam logic [CFG_IW-1:0] CFG_GAIN_RIGHT  = 2'd3;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_LW    = $clog2(Q_DEPTH + 1);

    localparam logic signed [25:0] MIX_MAX = 26'sd8388607;
    localparam logic signed [25:0] MIX_MIN = -26'sd8388608;
    localparam logic signed [32:0] ROUND_HALF = 33'sd16384;

    typedef struct packed {
        logic               opcode;
        logic signed [15:0] source_sample;
        logic               source_ended;
        logic signed [23:0] mix_left_in;
        logic signed [23:0] mix_right_in;
    } req_t;

    typedef struct packed {
        logic signed [23:0] mix_left_out;
        logic signed [23:0] mix_right_out;
        logic               sample_taken;
        logic               done_res;
    } res_t;

    typedef struct packed {
        logic [15:0] delay_left;
        logic [15:0] delay_right;
        logic [15:0] gain_left;
        logic [15:0] gain_right;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] tap_left;
        logic signed [15:0] tap_right;
        logic signed [23:0] mix_left;
        logic signed [23:0] mix_right;
        logic               sample_taken;
        logic               done_res;
    } q_item_t;

endpackage

### hw/rtl/sdpm_ram.sv
// ----------------------------------------------------------------------------
// sdpm_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sdpm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/sdpm_front.sv
// ----------------------------------------------------------------------------
// sdpm_front
// Voice sequencing: accepts requests, updates voice state, drives the delay
// line and hands classified items with their taps to the queue.
// ----------------------------------------------------------------------------
module sdpm_front
    import sdpm_pkg::*;
#(
    parameter int DELAY_DEPTH = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  cfg_t            cfg,
    input  logic            req_valid,
    output logic            req_stall,
    input  req_t            req,
    input  logic [Q_LW-1:0] q_level,
    output logic            push_valid,
    output q_item_t         push_item
);

    localparam int AW = $clog2(DELAY_DEPTH);
    localparam int DW = $clog2(DELAY_DEPTH + 1);
    localparam int TW = $clog2(DELAY_DEPTH + 2);

    logic [AW-1:0] wp_reg, wp_next;
    logic [15:0]   common_reg, common_next;
    logic [TW-1:0] tail_reg, tail_next;
    logic [DW-1:0] fill_reg, fill_next;
    logic          fin_reg, fin_next;
    logic          done_reg, done_next;

    logic               s1_valid_reg;
    logic signed [15:0] s1_cur_reg, cur;
    logic               s1_use_l_reg, use_l;
    logic               s1_use_r_reg, use_r;
    logic               s1_mem_ok_reg;
    logic signed [23:0] s1_mix_l_reg, s1_mix_r_reg;
    logic               s1_taken_reg, taken;
    logic               s1_done_reg, item_done;

    logic          accept;
    logic [15:0]   diff_raw, common_min;
    logic [DW-1:0] diff, wp_ext, rd_sum, fill_inc;
    logic [AW-1:0] rd_addr, wp_inc;
    logic [TW-1:0] tail_inc;
    logic          left_longer, right_longer, mem_ok, fin_now, ram_we;
    logic [15:0]   rdata;
    logic [Q_LW:0] credit_used;

    assign credit_used = {1'b0, q_level} + (Q_LW + 1)'(s1_valid_reg);
    assign req_stall   = credit_used >= (Q_LW + 1)'(Q_DEPTH);
    assign accept      = req_valid && !req_stall;

    assign left_longer  = cfg.delay_left > cfg.delay_right;
    assign right_longer = cfg.delay_right > cfg.delay_left;
    assign diff_raw     = left_longer ? cfg.delay_left - cfg.delay_right
                                      : cfg.delay_right - cfg.delay_left;
    assign diff         = (diff_raw > 16'(DELAY_DEPTH)) ? DW'(DELAY_DEPTH)
                                                        : diff_raw[DW-1:0];
    assign common_min   = (cfg.delay_left < cfg.delay_right) ? cfg.delay_left
                                                             : cfg.delay_right;

    assign wp_ext   = DW'(wp_reg);
    assign rd_sum   = (wp_ext >= diff) ? wp_ext - diff
                                       : wp_ext + DW'(DELAY_DEPTH) - diff;
    assign rd_addr  = rd_sum[AW-1:0];
    assign wp_inc   = (wp_reg == AW'(DELAY_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign fill_inc = (fill_reg < DW'(DELAY_DEPTH)) ? fill_reg + 1'b1 : fill_reg;
    assign tail_inc = (tail_reg <= TW'(DELAY_DEPTH)) ? tail_reg + 1'b1 : tail_reg;
    assign mem_ok   = fill_reg >= diff;
    assign fin_now  = fin_reg | req.source_ended;

    always_comb
    begin
        wp_next     = wp_reg;
        common_next = common_reg;
        tail_next   = tail_reg;
        fill_next   = fill_reg;
        fin_next    = fin_reg;
        done_next   = done_reg;
        cur         = '0;
        use_l       = 1'b0;
        use_r       = 1'b0;
        taken       = 1'b0;
        item_done   = 1'b0;
        ram_we      = 1'b0;
        if (accept)
        begin
            if (req.opcode == OP_START)
            begin
                wp_next     = '0;
                tail_next   = '0;
                fill_next   = '0;
                fin_next    = 1'b0;
                done_next   = 1'b0;
                common_next = common_min;
            end
            else if (done_reg)
            begin
                item_done = 1'b1;
            end
            else if (common_reg != 16'd0)
            begin
                common_next = common_reg - 1'b1;
            end
            else
            begin
                fin_next  = fin_now;
                cur       = fin_now ? 16'sd0 : req.source_sample;
                taken     = !fin_now;
                tail_next = fin_now ? tail_inc : tail_reg;
                ram_we    = 1'b1;
                wp_next   = wp_inc;
                fill_next = fill_inc;
                use_l     = left_longer;
                use_r     = right_longer;
                done_next = tail_next > TW'(diff);
                item_done = done_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg       <= '0;
            common_reg   <= '0;
            tail_reg     <= '0;
            fill_reg     <= '0;
            fin_reg      <= 1'b0;
            done_reg     <= 1'b1;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            wp_reg       <= wp_next;
            common_reg   <= common_next;
            tail_reg     <= tail_next;
            fill_reg     <= fill_next;
            fin_reg      <= fin_next;
            done_reg     <= done_next;
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cur_reg    <= cur;
            s1_use_l_reg  <= use_l;
            s1_use_r_reg  <= use_r;
            s1_mem_ok_reg <= mem_ok;
            s1_mix_l_reg  <= req.mix_left_in;
            s1_mix_r_reg  <= req.mix_right_in;
            s1_taken_reg  <= taken;
            s1_done_reg   <= item_done;
        end
    end

    sdpm_ram #(
        .WIDTH (16),
        .DEPTH (DELAY_DEPTH)
    ) u_delay_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (cur),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    // entries not yet written since start read as zero
    assign push_valid             = s1_valid_reg;
    assign push_item.tap_left     = s1_use_l_reg ? (s1_mem_ok_reg ? signed'(rdata) : 16'sd0)
                                                 : s1_cur_reg;
    assign push_item.tap_right    = s1_use_r_reg ? (s1_mem_ok_reg ? signed'(rdata) : 16'sd0)
                                                 : s1_cur_reg;
    assign push_item.mix_left     = s1_mix_l_reg;
    assign push_item.mix_right    = s1_mix_r_reg;
    assign push_item.sample_taken = s1_taken_reg;
    assign push_item.done_res     = s1_done_reg;

endmodule

### hw/rtl/sdpm_queue.sv
// ----------------------------------------------------------------------------
// sdpm_queue
// Short FIFO between voice sequencing and the gain and mix datapath.
// ----------------------------------------------------------------------------
module sdpm_queue
    import sdpm_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    input  q_item_t         push_item,
    input  logic            pop_ready,
    output logic            pop_valid,
    output q_item_t         pop_item,
    output logic [Q_LW-1:0] level
);

    q_item_t         mem [Q_DEPTH];
    logic [Q_AW-1:0] rd_ptr_reg, wr_ptr_reg;
    logic [Q_LW-1:0] count_reg, count_next;
    logic            pop;

    assign pop_valid = count_reg != '0;
    assign pop       = pop_valid && pop_ready;
    assign pop_item  = mem[rd_ptr_reg];
    assign level     = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push_valid && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push_valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push_valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### hw/rtl/sdpm_back.sv
// ----------------------------------------------------------------------------
// sdpm_back
// Gain and mix datapath: scales both taps, rounds, adds into the mix sums
// with 24-bit saturation and holds the result for the output channel.
// ----------------------------------------------------------------------------
module sdpm_back
    import sdpm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    pop_valid,
    input  q_item_t pop_item,
    output logic    pop_ready,
    output logic    res_valid,
    input  logic    res_stall,
    output res_t    res
);

    logic               a_valid_reg, b_valid_reg;
    logic signed [32:0] a_prod_l_reg, a_prod_r_reg;
    logic signed [23:0] a_mix_l_reg, a_mix_r_reg;
    logic               a_taken_reg, a_done_reg;
    res_t               b_res_reg;

    logic               a_ready, b_ready, a_load, b_load;
    logic signed [16:0] gain_l, gain_r;
    logic signed [32:0] prod_l, prod_r;
    logic signed [17:0] add_l, add_r;
    logic signed [25:0] sum_l, sum_r;
    logic signed [23:0] sat_l, sat_r;

    assign b_ready   = !b_valid_reg || !res_stall;
    assign a_ready   = !a_valid_reg || b_ready;
    assign pop_ready = a_ready;
    assign a_load    = pop_valid && a_ready;
    assign b_load    = a_valid_reg && b_ready;

    assign gain_l = signed'({1'b0, cfg.gain_left});
    assign gain_r = signed'({1'b0, cfg.gain_right});
    assign prod_l = pop_item.tap_left * gain_l + ROUND_HALF;
    assign prod_r = pop_item.tap_right * gain_r + ROUND_HALF;

    assign add_l = 18'(a_prod_l_reg >>> 15);
    assign add_r = 18'(a_prod_r_reg >>> 15);
    assign sum_l = 26'(a_mix_l_reg) + 26'(add_l);
    assign sum_r = 26'(a_mix_r_reg) + 26'(add_r);

    always_comb
    begin
        if (sum_l > MIX_MAX)
        begin
            sat_l = MIX_MAX[23:0];
        end
        else if (sum_l < MIX_MIN)
        begin
            sat_l = MIX_MIN[23:0];
        end
        else
        begin
            sat_l = sum_l[23:0];
        end
        if (sum_r > MIX_MAX)
        begin
            sat_r = MIX_MAX[23:0];
        end
        else if (sum_r < MIX_MIN)
        begin
            sat_r = MIX_MIN[23:0];
        end
        else
        begin
            sat_r = sum_r[23:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= pop_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_prod_l_reg <= prod_l;
            a_prod_r_reg <= prod_r;
            a_mix_l_reg  <= pop_item.mix_left;
            a_mix_r_reg  <= pop_item.mix_right;
            a_taken_reg  <= pop_item.sample_taken;
            a_done_reg   <= pop_item.done_res;
        end
        if (b_load)
        begin
            b_res_reg.mix_left_out  <= sat_l;
            b_res_reg.mix_right_out <= sat_r;
            b_res_reg.sample_taken  <= a_taken_reg;
            b_res_reg.done_res      <= a_done_reg;
        end
    end

    assign res_valid = b_valid_reg;
    assign res       = b_res_reg;

endmodule

### hw/rtl/stereo_delay_pan_mixer.sv
// ----------------------------------------------------------------------------
// stereo_delay_pan_mixer
// One mixer voice: common delay countdown, per-channel delay tap, gain and
// saturating stereo mix, one result per request.
// ----------------------------------------------------------------------------
// Takes one request per clock cycle and returns one result per request, in
// order. The rate is set by the delay line RAM, which does one read and at
// most one write per tick in the cycle the request is accepted. Requests are
// held off only when the four-entry queue in front of the gain and mix
// datapath, counting the request already reading the RAM, is full. Start
// clears the delay line through a fill count, so there is no clearing pass.
// Configuration is to be written by the user only while no request is in
// flight; the block itself does not enforce this.
module stereo_delay_pan_mixer
    import sdpm_pkg::*;
#(
    parameter int DELAY_DEPTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data,
    input  logic              req_valid,
    output logic              req_stall,
    input  req_t              req,
    output logic              res_valid,
    input  logic              res_stall,
    output res_t              res
);

    cfg_t            cfg_reg;
    logic            push_valid, pop_valid, pop_ready;
    q_item_t         push_item, pop_item;
    logic [Q_LW-1:0] q_level;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DELAY_LEFT:  cfg_reg.delay_left  <= cfg_data;
                CFG_DELAY_RIGHT: cfg_reg.delay_right <= cfg_data;
                CFG_GAIN_LEFT:   cfg_reg.gain_left   <= cfg_data;
                CFG_GAIN_RIGHT:  cfg_reg.gain_right  <= cfg_data;
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    sdpm_front #(
        .DELAY_DEPTH (DELAY_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .q_level    (q_level),
        .push_valid (push_valid),
        .push_item  (push_item)
    );

    sdpm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .pop_ready  (pop_ready),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .level      (q_level)
    );

    sdpm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_item  (pop_item),
        .pop_ready (pop_ready),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule
